FILE: hw/rtl/led_comet_pkg.sv
// Shared widths, codes and reset values of the LED comet animator.
`timescale 1ns / 1ps

package led_comet_pkg;

   // Field and register widths.
   localparam int LedCountW = 11;
   localparam int TailW     = 4;
   localparam int BrightW   = 8;
   localparam int HueW      = 8;
   localparam int IndexW    = 10;
   localparam int ActionW   = 2;
   localparam int DivisorW  = TailW + 1;

   // Configuration port geometry.
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   // Default sizes of the block.
   localparam int MaxCometsDef = 4;
   localparam int MaxLedsDef   = 1024;

   // Longest tail that a render honours.
   localparam logic [TailW-1:0] TailMax = 4'd14;

   // Action codes of an input word.
   localparam logic [ActionW-1:0] ACT_ADVANCE = 2'd0;
   localparam logic [ActionW-1:0] ACT_LAUNCH  = 2'd1;
   localparam logic [ActionW-1:0] ACT_RENDER  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_LED_COUNT = 2'd0;
   localparam logic [1:0] REG_TAIL_LEN  = 2'd1;
   localparam logic [1:0] REG_PEAK      = 2'd2;

   // Register reset values.
   localparam logic [LedCountW-1:0] LedCountRst = 11'd60;
   localparam logic [TailW-1:0]     TailLenRst  = 4'd4;
   localparam logic [BrightW-1:0]   PeakRst     = 8'd255;

endpackage

FILE: hw/rtl/led_comet_ifs.sv
// Handshake channels for input words and pixel write words.
`timescale 1ns / 1ps

interface led_comet_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [led_comet_pkg::ActionW-1:0]    action;
   logic [led_comet_pkg::HueW-1:0]       launch_hue;

   modport source (output valid, output action, output launch_hue, input ready);
   modport sink   (input valid, input action, input launch_hue, output ready);
endinterface

interface led_comet_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [led_comet_pkg::IndexW-1:0]     led_index;
   logic [led_comet_pkg::HueW-1:0]       pixel_hue;
   logic [led_comet_pkg::BrightW-1:0]    pixel_value;
   logic                                 last;

   modport source (output valid, output led_index, output pixel_hue, output pixel_value,
                   output last, input ready);
   modport sink   (input valid, input led_index, input pixel_hue, input pixel_value,
                   input last, output ready);
endinterface

FILE: hw/rtl/led_comet_animator_unit.sv
// Top level of the LED comet animator: slot store, sequencer and register port.
`timescale 1ns / 1ps

// The animator keeps MAX_COMETS comet slots and handles one input word at a
// time; req_ch.ready is low while a word is being worked on. A small sequencer
// walks the slots in turn through a single shared compare and add path.
// An advance is accepted and then walks every slot; a launch walks the slots
// until it claims the lowest free one or reaches the last. A render first runs
// the bit-serial divider that finds the brightness fall per tail segment, then
// visits each slot for its head, then each tail segment of every active slot
// (tail_length + 1 of them), and ends with a closing flush step. Each pixel
// write is held one step back so that the final write can carry last; a
// stalled result port holds the walk until the output register frees up.
// Registers sit at byte addresses 0, 4 and 8 and should be written only
// while the block is idle.
module led_comet_animator_unit #(
   parameter int MAX_COMETS = led_comet_pkg::MaxCometsDef,
   parameter int MAX_LEDS   = led_comet_pkg::MaxLedsDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   led_comet_req_if.sink                        req_ch,
   led_comet_rsp_if.source                      rsp_ch,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [led_comet_pkg::CsrAddrW-1:0]   paddr,
   input  logic [led_comet_pkg::CsrDataW-1:0]   pwdata,
   output logic [led_comet_pkg::CsrDataW-1:0]   prdata,
   output logic                                 pready
);

   localparam int LedW   = led_comet_pkg::LedCountW;
   localparam int TailW  = led_comet_pkg::TailW;
   localparam int BrW    = led_comet_pkg::BrightW;
   localparam int HueW   = led_comet_pkg::HueW;
   localparam int IdxW   = led_comet_pkg::IndexW;
   localparam int DivW   = led_comet_pkg::DivisorW;
   localparam int DataW  = led_comet_pkg::CsrDataW;
   localparam int SlotW  = (MAX_COMETS > 1) ? $clog2(MAX_COMETS) : 1;
   localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_COMETS - 1);
   localparam logic [LedW-1:0]  LedLimit = LedW'(MAX_LEDS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_HEADS,
      ST_TAILS,
      ST_FLUSH
   } state_type;

   // Registers.
   state_type        state_ff, state_in;
   logic [LedW-1:0]  led_count_ff, led_count_in;
   logic [TailW-1:0] tail_len_ff, tail_len_in;
   logic [BrW-1:0]   peak_ff, peak_in;
   logic [LedW-1:0]  head_ff [MAX_COMETS];
   logic [LedW-1:0]  head_in [MAX_COMETS];
   logic [MAX_COMETS-1:0] active_ff, active_in;
   logic [HueW-1:0]  hue_mem [MAX_COMETS];
   logic [HueW-1:0]  launch_hue_ff, launch_hue_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [TailW-1:0] seg_ff, seg_in;
   logic [BrW-1:0]   val_ff, val_in;
   logic [BrW-1:0]   step_ff, step_in;
   // Held-back pixel write.
   logic             pend_v_ff, pend_v_in;
   logic [IdxW-1:0]  pend_idx_ff, pend_idx_in;
   logic [HueW-1:0]  pend_hue_ff, pend_hue_in;
   logic [BrW-1:0]   pend_val_ff, pend_val_in;
   // Output register.
   logic             out_v_ff, out_v_in;
   logic [IdxW-1:0]  out_idx_ff, out_idx_in;
   logic [HueW-1:0]  out_hue_ff, out_hue_in;
   logic [BrW-1:0]   out_val_ff, out_val_in;
   logic             out_last_ff, out_last_in;

   // Combinational helpers.
   logic             cfg_wr;
   logic [LedW-1:0]  n_eff;
   logic [TailW-1:0] t_eff;
   logic [LedW:0]    free_limit;
   logic [LedW-1:0]  head_cur;
   logic             act_cur;
   logic [DivW-1:0]  back;
   logic [LedW-1:0]  tail_pos;
   logic [BrW-1:0]   tail_val;
   logic             cand_v;
   logic [IdxW-1:0]  cand_idx;
   logic [BrW-1:0]   cand_val;
   logic             out_free;
   logic             stall;
   logic             hue_we;
   logic             div_start;
   logic             div_done;
   logic [BrW-1:0]   div_quot;

   // Register writes complete on the access phase.
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   // Register read-back.
   always_comb begin
      case (paddr[3:2])
         led_comet_pkg::REG_LED_COUNT: prdata = DataW'(led_count_ff);
         led_comet_pkg::REG_TAIL_LEN:  prdata = DataW'(tail_len_ff);
         led_comet_pkg::REG_PEAK:      prdata = DataW'(peak_ff);
         default:                      prdata = '0;
      endcase
   end

   // Effective strip length and tail length.
   assign n_eff      = (led_count_ff > LedLimit) ? LedLimit : led_count_ff;
   assign t_eff      = (tail_len_ff > led_comet_pkg::TailMax) ? led_comet_pkg::TailMax
                                                              : tail_len_ff;
   assign free_limit = {1'b0, n_eff} + (LedW + 1)'(t_eff);

   // The slot under the sequencer and its current tail segment.
   assign head_cur = head_ff[slot_ff];
   assign act_cur  = active_ff[slot_ff];
   assign back     = {1'b0, seg_ff} + 1'b1;
   assign tail_pos = head_cur - LedW'(back);
   assign tail_val = val_ff - step_ff;

   // Candidate pixel write for this cycle.
   always_comb begin
      cand_v   = 1'b0;
      cand_idx = head_cur[IdxW-1:0];
      cand_val = peak_ff;
      case (state_ff)
         ST_HEADS: begin
            cand_v = act_cur && (head_cur < n_eff);
         end
         ST_TAILS: begin
            cand_v   = act_cur && (head_cur >= LedW'(back)) && (tail_pos < n_eff);
            cand_idx = tail_pos[IdxW-1:0];
            cand_val = tail_val;
         end
         default: begin
            cand_v = 1'b0;
         end
      endcase
   end

   assign out_free = !out_v_ff || rsp_ch.ready;
   assign stall    = cand_v && pend_v_ff && !out_free;

   // Sequencer and datapath next values.
   always_comb begin
      state_in      = state_ff;
      led_count_in  = led_count_ff;
      tail_len_in   = tail_len_ff;
      peak_in       = peak_ff;
      head_in       = head_ff;
      active_in     = active_ff;
      launch_hue_in = launch_hue_ff;
      slot_in       = slot_ff;
      seg_in        = seg_ff;
      val_in        = val_ff;
      step_in       = step_ff;
      pend_v_in     = pend_v_ff;
      pend_idx_in   = pend_idx_ff;
      pend_hue_in   = pend_hue_ff;
      pend_val_in   = pend_val_ff;
      out_v_in      = out_v_ff && !rsp_ch.ready;
      out_idx_in    = out_idx_ff;
      out_hue_in    = out_hue_ff;
      out_val_in    = out_val_ff;
      out_last_in   = out_last_ff;
      hue_we        = 1'b0;
      div_start     = 1'b0;

      if (cfg_wr) begin
         case (paddr[3:2])
            led_comet_pkg::REG_LED_COUNT: led_count_in = pwdata[LedW-1:0];
            led_comet_pkg::REG_TAIL_LEN:  tail_len_in  = pwdata[TailW-1:0];
            led_comet_pkg::REG_PEAK:      peak_in      = pwdata[BrW-1:0];
            default:                      led_count_in = led_count_ff;
         endcase
      end

      // A new pixel write pushes the held one out, not marked last.
      if (cand_v && !stall) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_idx_in  = pend_idx_ff;
            out_hue_in  = pend_hue_ff;
            out_val_in  = pend_val_ff;
            out_last_in = 1'b0;
         end
         pend_v_in   = 1'b1;
         pend_idx_in = cand_idx;
         pend_hue_in = hue_mem[slot_ff];
         pend_val_in = cand_val;
      end

      case (state_ff)
         ST_IDLE: begin
            slot_in       = '0;
            launch_hue_in = req_ch.launch_hue;
            if (req_ch.valid) begin
               case (req_ch.action)
                  led_comet_pkg::ACT_ADVANCE: state_in = ST_ADVANCE;
                  led_comet_pkg::ACT_LAUNCH:  state_in = ST_LAUNCH;
                  led_comet_pkg::ACT_RENDER: begin
                     state_in  = ST_DIVIDE;
                     div_start = 1'b1;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // Move each active head one step, or free it past the tail end.
         ST_ADVANCE: begin
            if (act_cur) begin
               if ({1'b0, head_cur} >= free_limit) begin
                  active_in[slot_ff] = 1'b0;
               end else begin
                  head_in[slot_ff] = head_cur + 1'b1;
               end
            end
            if (slot_ff == LastSlot) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end

         // Claim the lowest free slot.
         ST_LAUNCH: begin
            if (!act_cur) begin
               active_in[slot_ff] = 1'b1;
               head_in[slot_ff]   = '0;
               hue_we             = 1'b1;
               state_in           = ST_IDLE;
            end else if (slot_ff == LastSlot) begin
               state_in = ST_IDLE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end

         ST_DIVIDE: begin
            if (div_done) begin
               step_in  = div_quot;
               state_in = ST_HEADS;
            end
         end

         ST_HEADS: begin
            if (!stall) begin
               if (slot_ff == LastSlot) begin
                  slot_in  = '0;
                  seg_in   = '0;
                  val_in   = peak_ff;
                  state_in = ST_TAILS;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end

         // Walk the tail segments of each active slot, fading as it goes.
         ST_TAILS: begin
            if (!stall) begin
               if (!act_cur || (seg_ff == t_eff)) begin
                  seg_in = '0;
                  val_in = peak_ff;
                  if (slot_ff == LastSlot) begin
                     state_in = ST_FLUSH;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end else begin
                  seg_in = seg_ff + 1'b1;
                  val_in = tail_val;
               end
            end
         end

         // Release the held write as the final one of the render.
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_v_in    = 1'b1;
               out_idx_in  = pend_idx_ff;
               out_hue_in  = pend_hue_ff;
               out_val_in  = pend_val_ff;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         led_count_ff <= led_comet_pkg::LedCountRst;
         tail_len_ff  <= led_comet_pkg::TailLenRst;
         peak_ff      <= led_comet_pkg::PeakRst;
         active_ff    <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
         slot_ff      <= '0;
         seg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         led_count_ff <= led_count_in;
         tail_len_ff  <= tail_len_in;
         peak_ff      <= peak_in;
         active_ff    <= active_in;
         pend_v_ff    <= pend_v_in;
         out_v_ff     <= out_v_in;
         slot_ff      <= slot_in;
         seg_ff       <= seg_in;
      end
      head_ff       <= head_in;
      launch_hue_ff <= launch_hue_in;
      val_ff        <= val_in;
      step_ff       <= step_in;
      pend_idx_ff   <= pend_idx_in;
      pend_hue_ff   <= pend_hue_in;
      pend_val_ff   <= pend_val_in;
      out_idx_ff    <= out_idx_in;
      out_hue_ff    <= out_hue_in;
      out_val_ff    <= out_val_in;
      out_last_ff   <= out_last_in;
   end

   // Slot hue store, written only at a launch.
   always_ff @(posedge clock) begin
      if (hue_we) begin
         hue_mem[slot_ff] <= launch_hue_ff;
      end
   end

   // Brightness fall per segment: peak_brightness / (tail_length + 1).
   led_comet_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (peak_ff),
      .divisor  ({1'b0, t_eff} + 1'b1),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Channel ports.
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.led_index   = out_idx_ff;
   assign rsp_ch.pixel_hue   = out_hue_ff;
   assign rsp_ch.pixel_value = out_val_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule

FILE: hw/rtl/led_comet_div.sv
// Bit-serial restoring divider that works out the per-segment brightness fall.
`timescale 1ns / 1ps

module led_comet_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [led_comet_pkg::BrightW-1:0]     dividend,
   input  logic [led_comet_pkg::DivisorW-1:0]    divisor,
   output logic                                  done,
   output logic [led_comet_pkg::BrightW-1:0]     quotient
);

   localparam int DvdW = led_comet_pkg::BrightW;
   localparam int DivW = led_comet_pkg::DivisorW;
   localparam int CntW = $clog2(DvdW);

   logic [DvdW-1:0] dvd_ff, dvd_in;
   logic [DivW-2:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [DivW-1:0] rem_sh;
   logic [DivW-1:0] diff;
   logic            fits;

   // One quotient bit a cycle: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DvdW-1]};
      fits    = (rem_sh >= divisor);
      diff    = rem_sh - divisor;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = CntW'(DvdW - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[DvdW-2:0], fits};
         rem_in = fits ? diff[DivW-2:0] : rem_sh[DivW-2:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is cleared by reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
